>>> hw/rtl/lpcvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpcvs_pkg : shared types and constants of the victim select unit
// Fixed field widths, command codes, register map and the scan handshake.
// ----------------------------------------------------------------------------
package lpcvs_pkg;

   localparam int unsigned STAMP_W    = 32;
   localparam int unsigned SET_IN_W   = 6;
   localparam int unsigned HIT_WAY_W  = 3;
   localparam int unsigned DIRTY_W    = 8;
   localparam int unsigned VICTIM_W   = 3;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // command codes
   localparam logic CMD_ACCESS = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // register word index (paddr[2])
   localparam logic REG_PREFER_CLEAN = 1'b0;

   typedef struct packed {
      logic               start;
      logic               prefer_clean;
      logic               set_ok;
      logic [DIRTY_W-1:0] dirty_mask;
   } scan_req_type;

   typedef struct packed {
      logic                active;
      logic                done;
      logic [VICTIM_W-1:0] victim_way;
   } scan_rsp_type;

endpackage : lpcvs_pkg
`default_nettype wire

>>> hw/rtl/lpcvs_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lpcvs_scan : oldest-way search over one set row
// Walks the row one way a cycle, tracking the oldest way overall and the
// oldest clean way side by side; strobes the chosen way after the last one.
// ----------------------------------------------------------------------------
module lpcvs_scan #(
   parameter int unsigned NUM_WAYS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic [NUM_WAYS*lpcvs_pkg::STAMP_W-1:0] row,
   input  wire lpcvs_pkg::scan_req_type              scan_req,
   output lpcvs_pkg::scan_rsp_type                   scan_rsp
);
   import lpcvs_pkg::*;

   localparam int unsigned WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;

   logic               active_ff, active_in;
   logic               done_ff;
   logic [WAY_W-1:0]   way_ff;
   logic [DIRTY_W-1:0] dirty_ff;
   logic               pref_ff;
   logic               set_ok_ff;
   logic               all_have_ff, all_have_in;
   logic [WAY_W-1:0]   all_best_ff, all_best_in;
   logic [STAMP_W-1:0] all_stamp_ff, all_stamp_in;
   logic               cln_have_ff, cln_have_in;
   logic [WAY_W-1:0]   cln_best_ff, cln_best_in;
   logic [STAMP_W-1:0] cln_stamp_ff, cln_stamp_in;
   logic [VICTIM_W-1:0] victim_ff, victim_in;

   logic [STAMP_W-1:0] cur_stamp;
   logic [31:0]        way_ext;
   logic               clean;
   logic               last;
   logic [WAY_W-1:0]   pick;

   always_comb begin
      cur_stamp = row[way_ff*STAMP_W +: STAMP_W];
      way_ext   = 32'(way_ff);
      // ways past the dirty mask count as clean
      clean     = (way_ext >= DIRTY_W) || !dirty_ff[way_ext[2:0]];
      last      = (way_ext == NUM_WAYS - 1);

      all_have_in  = all_have_ff;
      all_best_in  = all_best_ff;
      all_stamp_in = all_stamp_ff;
      if (!all_have_ff || (cur_stamp < all_stamp_ff)) begin
         all_have_in  = 1'b1;
         all_best_in  = way_ff;
         all_stamp_in = cur_stamp;
      end

      cln_have_in  = cln_have_ff;
      cln_best_in  = cln_best_ff;
      cln_stamp_in = cln_stamp_ff;
      if (clean && (!cln_have_ff || (cur_stamp < cln_stamp_ff))) begin
         cln_have_in  = 1'b1;
         cln_best_in  = way_ff;
         cln_stamp_in = cur_stamp;
      end

      pick      = (pref_ff && cln_have_in) ? cln_best_in : all_best_in;
      victim_in = set_ok_ff ? VICTIM_W'(32'(pick)) : '0;

      active_in = active_ff;
      if (scan_req.start) begin
         active_in = 1'b1;
      end else if (active_ff && last) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= active_ff && last;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_req.start) begin
         way_ff      <= '0;
         dirty_ff    <= scan_req.dirty_mask;
         pref_ff     <= scan_req.prefer_clean;
         set_ok_ff   <= scan_req.set_ok;
         all_have_ff <= 1'b0;
         cln_have_ff <= 1'b0;
      end else if (active_ff) begin
         way_ff       <= WAY_W'(way_ff + 1'b1);
         all_have_ff  <= all_have_in;
         all_best_ff  <= all_best_in;
         all_stamp_ff <= all_stamp_in;
         cln_have_ff  <= cln_have_in;
         cln_best_ff  <= cln_best_in;
         cln_stamp_ff <= cln_stamp_in;
      end
      if (active_ff && last) begin
         victim_ff <= victim_in;
      end
   end

   assign scan_rsp.active     = active_ff;
   assign scan_rsp.done       = done_ff;
   assign scan_rsp.victim_way = victim_ff;

endmodule : lpcvs_scan
`default_nettype wire

>>> hw/rtl/lru_prefer_clean_victim_select_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_prefer_clean_victim_select_top : LRU victim select, clean ways first
// Access: busy stays low, next word may follow at once.
// Query: busy while the row is scanned (one way per cycle from the registered row
//   read); rsp_valid strobes after the last way, and a new word can be taken in
//   the cycle of that strobe. The receiver cannot stall.
// Reset: busy while the stamp memory is swept to zero, one set row a cycle;
//   register writes are taken throughout.
// ----------------------------------------------------------------------------
module lru_prefer_clean_victim_select_top #(
   parameter int unsigned NUM_SETS = 64,
   parameter int unsigned NUM_WAYS = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // command channel
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_cmd,
   input  wire logic [lpcvs_pkg::SET_IN_W-1:0]      req_set_index,
   input  wire logic                                req_hit_found,
   input  wire logic [lpcvs_pkg::HIT_WAY_W-1:0]     req_hit_way,
   input  wire logic [lpcvs_pkg::DIRTY_W-1:0]       req_dirty_mask,
   // result channel
   output logic                                     rsp_valid,
   output logic [lpcvs_pkg::VICTIM_W-1:0]           rsp_victim_way,
   // register port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [lpcvs_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [lpcvs_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lpcvs_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                     pready
);
   import lpcvs_pkg::*;

   localparam int unsigned SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int unsigned ROW_W = NUM_WAYS * STAMP_W;

   // one row per set, one 32-bit stamp lane per way
   logic [ROW_W-1:0]    stamp_mem [NUM_SETS];
   logic [ROW_W-1:0]    rd_row_ff;

   logic                pref_ff, pref_in;
   logic [STAMP_W-1:0]  use_ctr_ff, use_ctr_in;
   logic                clr_active_ff, clr_active_in;
   logic [SET_W-1:0]    clr_addr_ff, clr_addr_in;

   logic                accept;
   logic                set_ok;
   logic                way_ok;
   logic                acc_hit;
   logic                query;
   logic                csr_wr;

   logic                wr_en;
   logic [SET_W-1:0]    wr_addr;
   logic [NUM_WAYS-1:0] wr_mask;
   logic [STAMP_W-1:0]  wr_stamp;
   logic                rd_en;
   logic [SET_W-1:0]    rd_addr;

   scan_req_type        scan_req;
   scan_rsp_type        scan_rsp;

   // ------------------------------------------------------------------
   // Command decode. Busy covers the clearing sweep and a running scan,
   // so a stamp row is never written while its copy is being searched.
   // ------------------------------------------------------------------
   assign busy    = clr_active_ff || scan_rsp.active;
   assign accept  = start && !busy;
   assign set_ok  = (32'(req_set_index) < NUM_SETS);
   assign way_ok  = (32'(req_hit_way) < NUM_WAYS);
   assign acc_hit = accept && (req_cmd == CMD_ACCESS) && req_hit_found && set_ok && way_ok;
   assign query   = accept && (req_cmd == CMD_QUERY);

   // global use counter, wraps
   assign use_ctr_in = acc_hit ? (use_ctr_ff + 1'b1) : use_ctr_ff;

   // ------------------------------------------------------------------
   // Clearing sweep after reset
   // ------------------------------------------------------------------
   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = SET_W'(clr_addr_ff + 1'b1);
         if (clr_addr_ff == SET_W'(NUM_SETS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Memory port control: a hit writes only its own lane, so no read
   // is needed on the access path; the sweep writes whole rows.
   // ------------------------------------------------------------------
   always_comb begin
      wr_en    = clr_active_ff || acc_hit;
      wr_addr  = clr_active_ff ? clr_addr_ff : SET_W'(req_set_index);
      wr_stamp = clr_active_ff ? '0 : use_ctr_in;
      for (int w = 0; w < NUM_WAYS; w++) begin
         wr_mask[w] = clr_active_ff || (32'(req_hit_way) == w);
      end
      rd_en   = query && set_ok;
      rd_addr = SET_W'(req_set_index);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (wr_mask[w]) begin
               stamp_mem[wr_addr][w*STAMP_W +: STAMP_W] <= wr_stamp;
            end
         end
      end
      if (rd_en) begin
         rd_row_ff <= stamp_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------
   // Oldest-way search; starts on the accepting edge, sees the row next
   // cycle. An out-of-range set still scans but reports way 0.
   // ------------------------------------------------------------------
   always_comb begin
      scan_req.start        = query;
      scan_req.prefer_clean = pref_ff;
      scan_req.set_ok       = set_ok;
      scan_req.dirty_mask   = req_dirty_mask;
   end

   lpcvs_scan #(
      .NUM_WAYS (NUM_WAYS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .row      (rd_row_ff),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp)
   );

   assign rsp_valid      = scan_rsp.done;
   assign rsp_victim_way = scan_rsp.victim_way;

   // ------------------------------------------------------------------
   // Register port: word 0 holds prefer_clean in bit 0
   // ------------------------------------------------------------------
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign pref_in = (csr_wr && (paddr[2] == REG_PREFER_CLEAN)) ? pwdata[0] : pref_ff;

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_PREFER_CLEAN) begin
         prdata[0] = pref_ff;
      end
   end

   // ------------------------------------------------------------------
   // Control registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pref_ff       <= 1'b0;
         use_ctr_ff    <= '0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         pref_ff       <= pref_in;
         use_ctr_ff    <= use_ctr_in;
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

endmodule : lru_prefer_clean_victim_select_top
`default_nettype wire

>>> tb/sv/lru_prefer_clean_victim_select_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_prefer_clean_victim_select_top_tb : self-checking bench for victim select
// Drives access and query words on the command channel. A local model of the
// per-way stamps, use counter and prefer-clean bit predicts each victim. Every
// rsp_valid strobe is checked against the oldest prediction. Directed cases
// come first, then random phases under both register settings.
// ----------------------------------------------------------------------------
module lru_prefer_clean_victim_select_top_tb;
   import lpcvs_pkg::*;

   localparam int unsigned NUM_SETS   = 64;
   localparam int unsigned NUM_WAYS   = 8;
   // no word accepted, no result and no register access for this long means a hang
   localparam int unsigned HANG_LIMIT = 2000;
   localparam logic [CSR_ADDR_W-1:0] PREFER_CLEAN_ADDR = {REG_PREFER_CLEAN, 2'b00};

   typedef struct packed {
      logic                 cmd;
      logic [SET_IN_W-1:0]  set_index;
      logic                 hit_found;
      logic [HIT_WAY_W-1:0] hit_way;
      logic [DIRTY_W-1:0]   dirty_mask;
   } cache_word_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_cmd;
   logic [SET_IN_W-1:0]   req_set_index;
   logic                  req_hit_found;
   logic [HIT_WAY_W-1:0]  req_hit_way;
   logic [DIRTY_W-1:0]    req_dirty_mask;
   logic                  rsp_valid;
   logic [VICTIM_W-1:0]   rsp_victim_way;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // local copy of the replacement state
   logic [STAMP_W-1:0]    way_age [NUM_SETS][NUM_WAYS];
   logic [STAMP_W-1:0]    use_count;
   logic                  prefer_clean_cfg;

   logic [VICTIM_W-1:0]   expected_victims [$];
   logic [SET_IN_W-1:0]   hot_sets [4];
   int unsigned           error_count = 0;
   int unsigned           quiet_cycles = 0;
   logic [VICTIM_W-1:0]   victim_due;

   lru_prefer_clean_victim_select_top #(
      .NUM_SETS(NUM_SETS),
      .NUM_WAYS(NUM_WAYS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_set_index  (req_set_index),
      .req_hit_found  (req_hit_found),
      .req_hit_way    (req_hit_way),
      .req_dirty_mask (req_dirty_mask),
      .rsp_valid      (rsp_valid),
      .rsp_victim_way (rsp_victim_way),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Oldest way of a set: strictly smaller stamp wins, so the lowest index
   // keeps ties. A found flag, not a sentinel, so an all-ones stamp still
   // competes. With prefer-clean, dirty ways sit out unless every way is dirty.
   function automatic logic [VICTIM_W-1:0] oldest_way(input logic [SET_IN_W-1:0] set_sel,
                                                       input logic [DIRTY_W-1:0]  dirty);
      logic [STAMP_W-1:0]  low_stamp;
      logic                have;
      logic [VICTIM_W-1:0] pick;
      have      = 1'b0;
      pick      = '0;
      low_stamp = '0;
      if (prefer_clean_cfg) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (!dirty[w] && (!have || way_age[set_sel][w] < low_stamp)) begin
               have      = 1'b1;
               pick      = w[VICTIM_W-1:0];
               low_stamp = way_age[set_sel][w];
            end
         end
      end
      if (!have) begin
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (!have || way_age[set_sel][w] < low_stamp) begin
               have      = 1'b1;
               pick      = w[VICTIM_W-1:0];
               low_stamp = way_age[set_sel][w];
            end
         end
      end
      return pick;
   endfunction

   // A hit bumps the wrapping counter and stamps the way; a miss is a no-op.
   // hit fields are ignored by queries, dirty_mask by accesses.
   task automatic apply_word(input cache_word_type wd);
      if (wd.cmd == CMD_ACCESS) begin
         if (wd.hit_found) begin
            use_count = use_count + 1'b1;
            way_age[wd.set_index][wd.hit_way] = use_count;
         end
      end else begin
         expected_victims.push_back(oldest_way(wd.set_index, wd.dirty_mask));
      end
   endtask

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   function automatic cache_word_type make_word(input logic                 cmd,
                                                input logic [SET_IN_W-1:0]  set_sel,
                                                input logic                 hit,
                                                input logic [HIT_WAY_W-1:0] way,
                                                input logic [DIRTY_W-1:0]   dirty);
      cache_word_type wd;
      wd.cmd        = cmd;
      wd.set_index  = set_sel;
      wd.hit_found  = hit;
      wd.hit_way    = way;
      wd.dirty_mask = dirty;
      return wd;
   endfunction

   // Holds start low over the gap, then presents the word until busy is low
   // at a rising edge. start stays high afterwards so back-to-back words
   // never drop it.
   task automatic send_word(input cache_word_type wd, input int unsigned gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start          <= 1'b1;
      req_cmd        <= wd.cmd;
      req_set_index  <= wd.set_index;
      req_hit_found  <= wd.hit_found;
      req_hit_way    <= wd.hit_way;
      req_dirty_mask <= wd.dirty_mask;
      do @(posedge clock); while (busy !== 1'b0);
      apply_word(wd);
   endtask

   // sender pause: start dropped until every predicted victim has come back
   task automatic wait_results_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_victims.size() != 0) @(posedge clock);
   endtask

   // accesses leave no result, so allow the query latency to run out as well
   task automatic wait_idle();
      wait_results_drained();
      repeat (NUM_WAYS + 4) @(posedge clock);
   endtask

   // one APB transfer to the prefer_clean register; a read is checked
   task automatic csr_transfer(input logic is_write, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= PREFER_CLEAN_ADDR;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (is_write) begin
         prefer_clean_cfg = data[0];
      end else if (prdata !== {{(CSR_DATA_W-1){1'b0}}, prefer_clean_cfg}) begin
         error_count++;
         $display("%0t: prefer_clean read, expected %0h, actual %0h",
                  $time, prefer_clean_cfg, prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // mix of masks: all dirty (fallback), all clean, one clean way, one dirty
   // way, and plain random bytes
   function automatic logic [DIRTY_W-1:0] random_dirty();
      case ($urandom_range(0, 5))
         0: return 8'hFF;
         1: return 8'h00;
         2: return ~(8'h01 << $urandom_range(0, 7));
         3: return 8'h01 << $urandom_range(0, 7);
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly hits to a few hot sets so stamps build up and queries see real
   // ordering; some misses, and a fifth of words to any set.
   function automatic cache_word_type random_word();
      logic [SET_IN_W-1:0] set_sel;
      int unsigned         kind;
      set_sel = ($urandom_range(0, 4) == 0) ? SET_IN_W'($urandom_range(0, NUM_SETS - 1))
                                            : hot_sets[$urandom_range(0, 3)];
      kind    = $urandom_range(0, 19);
      if (kind < 11) begin
         return make_word(CMD_ACCESS, set_sel, 1'b1, HIT_WAY_W'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)));
      end else if (kind < 13) begin
         return make_word(CMD_ACCESS, set_sel, 1'b0, HIT_WAY_W'($urandom_range(0, 7)),
                          8'($urandom_range(0, 255)));
      end
      return make_word(CMD_QUERY, set_sel, 1'($urandom_range(0, 1)),
                       HIT_WAY_W'($urandom_range(0, 7)), random_dirty());
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Stamps all zero after the clearing sweep: every query ties, way 0 wins.
   // The register must read back its reset value.
   task automatic test_reset_state();
      send_word(make_word(CMD_QUERY, 6'd0, 1'b1, 3'd7, 8'($urandom_range(0, 255))), 0);
      send_word(make_word(CMD_QUERY, 6'd63, 1'b0, 3'd0, 8'($urandom_range(0, 255))), 0);
      wait_idle();
      csr_transfer(1'b0, '0);
   endtask

   // Plain LRU on the edge sets: fill set 63 from way 7 down so way 7 is
   // oldest, a miss on way 7 must not refresh it, dirty bits are ignored.
   task automatic test_plain_lru();
      csr_transfer(1'b1, 32'd0);
      csr_transfer(1'b0, '0);
      for (int w = NUM_WAYS - 1; w >= 0; w--)
         send_word(make_word(CMD_ACCESS, 6'd63, 1'b1, HIT_WAY_W'(w),
                             8'($urandom_range(0, 255))), $urandom_range(0, 3));
      send_word(make_word(CMD_ACCESS, 6'd63, 1'b0, 3'd7, 8'hFF), 0);
      send_word(make_word(CMD_QUERY, 6'd63, 1'b1, 3'd7, 8'hFF), 0);
      send_word(make_word(CMD_ACCESS, 6'd0, 1'b1, 3'd0, 8'h00), 0);
      send_word(make_word(CMD_QUERY, 6'd0, 1'b0, 3'd0, 8'h00), 0);
   endtask

   // Prefer-clean: oldest clean way, single clean way, and the fall back to
   // plain LRU when every way is dirty.
   task automatic test_prefer_clean();
      wait_idle();
      csr_transfer(1'b1, 32'd1);
      csr_transfer(1'b0, '0);
      send_word(make_word(CMD_QUERY, 6'd63, 1'b0, 3'd0, 8'h80), 0);
      send_word(make_word(CMD_QUERY, 6'd63, 1'b1, 3'd5, 8'hFF), 0);
      send_word(make_word(CMD_QUERY, 6'd63, 1'b0, 3'd2, 8'h7F), $urandom_range(0, 3));
      send_word(make_word(CMD_QUERY, 6'd0, 1'b1, 3'd7, 8'hFE), 0);
      send_word(make_word(CMD_QUERY, 6'd0, 1'b0, 3'd1, 8'h01), 0);
      send_word(make_word(CMD_QUERY, 6'd0, 1'b1, 3'd4, 8'h00), 0);
   endtask

   // Sender stalls with queries in flight until all results are home, then
   // resumes straight into another query.
   task automatic test_drain_pause();
      send_word(make_word(CMD_ACCESS, 6'd63, 1'b1, 3'd3, 8'h00), 0);
      send_word(make_word(CMD_QUERY, 6'd63, 1'b0, 3'd0, random_dirty()), 0);
      send_word(make_word(CMD_QUERY, 6'd63, 1'b1, 3'd0, random_dirty()), 0);
      wait_results_drained();
      send_word(make_word(CMD_QUERY, 6'd63, 1'b0, 3'd6, random_dirty()), 0);
   endtask

   // One random phase under a fixed register setting. Random idle gaps between
   // words, with stretches of back-to-back words and the odd full drain.
   task automatic test_random_phase(input int unsigned words, input logic mode);
      logic        no_idle;
      int unsigned gap;
      no_idle = 1'b0;
      wait_idle();
      csr_transfer(1'b1, {{(CSR_DATA_W-1){1'b0}}, mode});
      csr_transfer(1'b0, '0);
      for (int h = 0; h < 4; h++) hot_sets[h] = SET_IN_W'($urandom_range(0, NUM_SETS - 1));
      for (int n = 0; n < words; n++) begin
         if (n % 32 == 0) no_idle = ($urandom_range(0, 2) == 0);
         gap = no_idle ? 0 : $urandom_range(0, 16);
         if (n % 97 == 96) wait_results_drained();
         send_word(random_word(), gap);
      end
   endtask

   // -------------------------------------------------------------------------
   // Result check: each strobe against the oldest predicted victim
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_valid === 1'b1) begin
         if (expected_victims.size() == 0) begin
            error_count++;
            $display("%0t: victim_way with none pending, expected none, actual %0d",
                     $time, rsp_victim_way);
         end else begin
            victim_due = expected_victims.pop_front();
            if (rsp_victim_way !== victim_due) begin
               error_count++;
               $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                        $time, victim_due, rsp_victim_way);
            end
         end
      end
   end

   // Hang guard: cycles with no word taken, no result and no register access.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1 ||
          (psel === 1'b1 && penable === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("lru_prefer_clean_victim_select_top_tb failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = CMD_ACCESS;
      req_set_index  = '0;
      req_hit_found  = 1'b0;
      req_hit_way    = '0;
      req_dirty_mask = '0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      use_count        = '0;
      prefer_clean_cfg = 1'b0;
      for (int s = 0; s < NUM_SETS; s++)
         for (int w = 0; w < NUM_WAYS; w++)
            way_age[s][w] = '0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_plain_lru();
      test_prefer_clean();
      test_drain_pause();
      test_random_phase(300, 1'b1);
      test_random_phase(300, 1'b0);
      test_random_phase(300, 1'b1);
      test_random_phase(300, 1'b0);

      // drain, then leave room for a late or stray strobe
      wait_results_drained();
      repeat (NUM_WAYS + 4) @(posedge clock);
      if (expected_victims.size() != 0) begin
         error_count++;
         $display("%0t: victims outstanding at end, expected 0, actual %0d",
                  $time, expected_victims.size());
      end
      if (error_count == 0) begin
         $display("lru_prefer_clean_victim_select_top_tb passed");
      end else begin
         $display("lru_prefer_clean_victim_select_top_tb failed");
      end
      $finish;
   end

endmodule : lru_prefer_clean_victim_select_top_tb
`default_nettype wire

>>> lru_prefer_clean_victim_select_top.f
hw/rtl/lpcvs_pkg.sv
hw/rtl/lpcvs_scan.sv
hw/rtl/lru_prefer_clean_victim_select_top.sv
tb/sv/lru_prefer_clean_victim_select_top_tb.sv
